### hdl/obp_pkg.sv
// shared types, constants and the per-family step programs for the polynomial basis block
// no dependencies
package obp_pkg;

    localparam int ABS_W      = 29;
    localparam int VAL_W      = 64;
    localparam int ORD_W      = 4;
    localparam int CNT_W      = 5;
    localparam int CFG_W      = 5;
    localparam int RECIP_BITS = 32;
    localparam int STEP_W     = 3;

    typedef enum logic [1:0] {
        FAM_CHEB,
        FAM_LEG,
        FAM_MONO,
        FAM_HERM
    } t_family;

    typedef enum logic [0:0] {
        REG_FAMILY,
        REG_TERM_COUNT
    } t_reg;

    typedef enum logic [1:0] {
        K_MUL,
        K_ADD,
        K_SUB,
        K_END
    } t_kind;

    typedef enum logic [3:0] {
        SRC_X,
        SRC_TWO_X,
        SRC_V1,
        SRC_V2,
        SRC_D1,
        SRC_D2,
        SRC_T0,
        SRC_T1,
        SRC_T2,
        SRC_C,
        SRC_NM1,
        SRC_N,
        SRC_TWO_NM1,
        SRC_TWO_N,
        SRC_TWO,
        SRC_RECIP
    } t_src;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_FRAC,
        SH_RECIP
    } t_shift;

    typedef enum logic [1:0] {
        D_T0,
        D_T1,
        D_T2
    } t_dst;

    typedef struct packed {
        t_kind  kind;
        t_src   a;
        t_src   b;
        t_shift sh;
        t_dst   dst;
    } t_op;

    typedef struct packed {
        logic load;
        logic issue;
        logic alu;
        logic emit;
        logic last;
        t_op  op;
    } t_ctrl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_WAIT,
        S_EMIT
    } t_state;

    function automatic t_op mk_op(t_kind k, t_src a, t_src b, t_shift sh, t_dst dst);
        t_op op;
        op.kind = k;
        op.a    = a;
        op.b    = b;
        op.sh   = sh;
        op.dst  = dst;
        return op;
    endfunction

    // micro program for orders two and up; value ends in t0, slope in t1
    function automatic t_op op_decode(t_family fam, logic [STEP_W-1:0] step);
        t_op op;
        op = mk_op(K_END, SRC_T0, SRC_T0, SH_NONE, D_T0);
        case (fam)
            FAM_CHEB: begin
                case (step)
                    3'd0: op = mk_op(K_MUL, SRC_TWO_X, SRC_V1, SH_FRAC, D_T0);
                    3'd1: op = mk_op(K_SUB, SRC_T0, SRC_V2, SH_NONE, D_T0);
                    3'd2: op = mk_op(K_MUL, SRC_TWO_X, SRC_D1, SH_FRAC, D_T1);
                    3'd3: op = mk_op(K_MUL, SRC_V1, SRC_TWO, SH_NONE, D_T2);
                    3'd4: op = mk_op(K_ADD, SRC_T1, SRC_T2, SH_NONE, D_T1);
                    3'd5: op = mk_op(K_SUB, SRC_T1, SRC_D2, SH_NONE, D_T1);
                    default: ;
                endcase
            end
            FAM_LEG: begin
                case (step)
                    3'd0: op = mk_op(K_MUL, SRC_X, SRC_C, SH_NONE, D_T0);
                    3'd1: op = mk_op(K_MUL, SRC_T0, SRC_V1, SH_FRAC, D_T0);
                    3'd2: op = mk_op(K_MUL, SRC_V2, SRC_NM1, SH_NONE, D_T1);
                    3'd3: op = mk_op(K_SUB, SRC_T0, SRC_T1, SH_NONE, D_T0);
                    3'd4: op = mk_op(K_MUL, SRC_T0, SRC_RECIP, SH_RECIP, D_T0);
                    3'd5: op = mk_op(K_MUL, SRC_V1, SRC_C, SH_NONE, D_T1);
                    3'd6: op = mk_op(K_ADD, SRC_T1, SRC_D2, SH_NONE, D_T1);
                    default: ;
                endcase
            end
            FAM_MONO: begin
                case (step)
                    3'd0: op = mk_op(K_MUL, SRC_X, SRC_V1, SH_FRAC, D_T0);
                    3'd1: op = mk_op(K_MUL, SRC_V1, SRC_N, SH_NONE, D_T1);
                    default: ;
                endcase
            end
            default: begin
                case (step)
                    3'd0: op = mk_op(K_MUL, SRC_TWO_X, SRC_V1, SH_FRAC, D_T0);
                    3'd1: op = mk_op(K_MUL, SRC_V2, SRC_TWO_NM1, SH_NONE, D_T1);
                    3'd2: op = mk_op(K_SUB, SRC_T0, SRC_T1, SH_NONE, D_T0);
                    3'd3: op = mk_op(K_MUL, SRC_V1, SRC_TWO_N, SH_NONE, D_T1);
                    default: ;
                endcase
            end
        endcase
        return op;
    endfunction

endpackage

### hdl/obp_mul.sv
// shared multiplier: signed 64x64 product from four 32x32 partial products,
// rounded half away from zero and shifted right when a shift is selected, saturated to 64 bits; uses obp_pkg
module obp_mul #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [obp_pkg::VAL_W-1:0]     i_a,
    input  logic signed [obp_pkg::VAL_W-1:0]     i_b,
    input  obp_pkg::t_shift                      i_shift,
    output logic                                 o_done,
    output logic signed [obp_pkg::VAL_W-1:0]     o_result,
    output logic                                 o_sat
);
    import obp_pkg::*;

    localparam int ACC_W = 2 * VAL_W;
    localparam logic [ACC_W-1:0] HALF_FRAC  = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [ACC_W-1:0] HALF_RECIP = ACC_W'(1) << (RECIP_BITS - 1);
    localparam logic [VAL_W-1:0] POS_MAX    = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] NEG_MIN    = {1'b1, {(VAL_W-1){1'b0}}};

    logic                r_run;
    logic [1:0]          r_phase;
    logic                r_pp_vld;
    logic                r_pp_last;
    logic                r_fin;
    logic                r_done;
    logic [VAL_W-1:0]    r_ua;
    logic [VAL_W-1:0]    r_ub;
    logic                r_neg;
    t_shift              r_shift;
    logic [VAL_W-1:0]    r_pp;
    logic [1:0]          r_pp_pos;
    logic [ACC_W-1:0]    r_acc;
    logic [VAL_W-1:0]    r_result;
    logic                r_sat;

    logic [ACC_W-1:0]    half;
    logic [ACC_W-1:0]    shifted;
    logic [VAL_W-1:0]    limit;
    logic [VAL_W-1:0]    mag;
    logic                over;
    logic [VAL_W-1:0]    fin_val;

    always_comb begin
        case (i_shift)
            SH_NONE:  half = '0;
            SH_FRAC:  half = HALF_FRAC;
            SH_RECIP: half = HALF_RECIP;
            default:  half = '0;
        endcase
    end

    always_comb begin
        case (r_shift)
            SH_NONE:  shifted = r_acc;
            SH_FRAC:  shifted = r_acc >> FRAC_BITS;
            SH_RECIP: shifted = r_acc >> RECIP_BITS;
            default:  shifted = r_acc;
        endcase
        limit = r_neg ? NEG_MIN : POS_MAX;
        mag   = shifted[VAL_W-1:0];
        over  = (|shifted[ACC_W-1:VAL_W]) || (mag > limit);
        if (over) begin
            fin_val = r_neg ? NEG_MIN : POS_MAX;
        end else begin
            fin_val = r_neg ? (~mag + 1'b1) : mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_phase   <= '0;
            r_pp_vld  <= 1'b0;
            r_pp_last <= 1'b0;
            r_fin     <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_pp_vld  <= r_run;
            r_pp_last <= r_run && (r_phase == 2'd3);
            r_fin     <= r_pp_vld && r_pp_last;
            r_done    <= r_fin;
            if (i_start) begin
                r_run   <= 1'b1;
                r_phase <= '0;
            end else if (r_run) begin
                r_phase <= r_phase + 1'b1;
                if (r_phase == 2'd3) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua    <= i_a[VAL_W-1] ? (~i_a + 1'b1) : i_a;
            r_ub    <= i_b[VAL_W-1] ? (~i_b + 1'b1) : i_b;
            r_neg   <= i_a[VAL_W-1] ^ i_b[VAL_W-1];
            r_shift <= i_shift;
            r_acc   <= half;
        end else if (r_pp_vld) begin
            r_acc <= r_acc + (ACC_W'(r_pp) << {r_pp_pos, 5'd0});
        end
        if (r_run) begin
            r_pp     <= VAL_W'(r_ua[{r_phase[1], 5'd0} +: 32]) *
                        VAL_W'(r_ub[{r_phase[0], 5'd0} +: 32]);
            r_pp_pos <= {1'b0, r_phase[1]} + {1'b0, r_phase[0]};
        end
        if (r_fin) begin
            r_result <= fin_val;
            r_sat    <= over;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;
    assign o_sat    = r_sat;

endmodule

### hdl/obp_ctrl.sv
// sequencer: walks the orders of one abscissa and the step program of each order
// depends on obp_pkg for the state, op and control types
module obp_ctrl #(
    parameter int  MAX_TERMS = 16,
    localparam int NW        = $clog2(MAX_TERMS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  obp_pkg::t_family i_family,
    input  logic [NW-1:0]    i_count_m1,
    input  logic             i_mul_done,
    output logic             o_busy,
    output logic [NW-1:0]    o_order,
    output obp_pkg::t_ctrl   o_ctrl
);
    import obp_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [NW-1:0]       r_order;
    logic [NW-1:0]       n_order;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;
    t_op                 op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_order <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_order <= n_order;
            r_step  <= n_step;
        end
    end

    always_comb begin
        op = op_decode(i_family, r_step);
        // orders zero and one are closed forms, no steps
        if (r_order <= NW'(1)) begin
            op.kind = K_END;
        end
        n_state   = r_state;
        n_order   = r_order;
        n_step    = r_step;
        o_ctrl    = '0;
        o_ctrl.op = op;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctrl.load = 1'b1;
                    n_order     = '0;
                    n_step      = '0;
                    n_state     = S_STEP;
                end
            end
            S_STEP: begin
                unique case (op.kind) inside
                    K_MUL: begin
                        o_ctrl.issue = 1'b1;
                        n_state      = S_WAIT;
                    end
                    K_ADD, K_SUB: begin
                        o_ctrl.alu = 1'b1;
                        n_step     = r_step + 1'b1;
                    end
                    default: begin
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_WAIT: begin
                if (i_mul_done) begin
                    n_step  = r_step + 1'b1;
                    n_state = S_STEP;
                end
            end
            S_EMIT: begin
                o_ctrl.emit = 1'b1;
                o_ctrl.last = (r_order == i_count_m1);
                if (o_ctrl.last) begin
                    n_state = S_IDLE;
                end else begin
                    n_order = r_order + 1'b1;
                    n_step  = '0;
                    n_state = S_STEP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_order = r_order;

endmodule

### hdl/orthogonal_polynomial_basis.sv
// orders 0 and 1 are closed forms with no steps; higher orders run their family's step program,
// waiting on the shared multiplier for each multiply and using the saturating adder for each add
// or subtract, then emit; busy stays high for the run
// one result per order on o_valid; start is taken again once the last result is out
// synchronous active-low reset: family chebyshev, term_count 1, sequencer idle; no clearing pass
// top level: config registers, operand select, saturating adder, recurrence state; obp_ctrl, obp_mul
module orthogonal_polynomial_basis #(
    parameter int MAX_TERMS = 16,
    parameter int FRAC_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_cfg_we,
    input  logic [0:0]                           i_cfg_index,
    input  logic [obp_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic signed [obp_pkg::ABS_W-1:0]     i_abscissa,
    output logic                                 o_valid,
    output logic [obp_pkg::ORD_W-1:0]            o_order_index,
    output logic signed [obp_pkg::VAL_W-1:0]     o_basis_value,
    output logic signed [obp_pkg::VAL_W-1:0]     o_basis_slope,
    output logic                                 o_saturated,
    output logic                                 o_last_of_run
);
    import obp_pkg::*;

    localparam int NW        = $clog2(MAX_TERMS);
    localparam int ROM_DEPTH = 1 << NW;
    localparam logic [VAL_W-1:0] ONE_VAL = VAL_W'(1) << FRAC_BITS;
    localparam logic [VAL_W-1:0] POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] NEG_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    t_family                 r_family;
    logic [CNT_W-1:0]        r_term_count;
    logic signed [ABS_W-1:0] r_x;
    logic [VAL_W-1:0]        r_v1;
    logic [VAL_W-1:0]        r_v2;
    logic [VAL_W-1:0]        r_d1;
    logic [VAL_W-1:0]        r_d2;
    logic [VAL_W-1:0]        r_t0;
    logic [VAL_W-1:0]        r_t1;
    logic [VAL_W-1:0]        r_t2;
    logic                    r_sat_acc;
    logic                    r_valid;

    t_ctrl                   ctrl;
    logic [NW-1:0]           order;
    logic [NW-1:0]           count_m1;
    logic                    mul_done;
    logic [VAL_W-1:0]        mul_res;
    logic                    mul_sat;

    logic [32:0]             recip_rom [ROM_DEPTH];
    logic [VAL_W-1:0]        x_ext;
    logic [VAL_W-1:0]        two_x;
    logic [VAL_W-1:0]        ord_ext;
    logic [VAL_W-1:0]        opa;
    logic [VAL_W-1:0]        opb;
    logic [VAL_W-1:0]        sum;
    logic                    ovf;
    logic [VAL_W-1:0]        alu_res;
    logic [VAL_W-1:0]        emit_val;
    logic [VAL_W-1:0]        emit_slope;
    logic [NW+ORD_W-1:0]     order_wide;

    // reciprocal table round(2^32 / n); entry zero duplicates entry one
    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_recip
        localparam longint unsigned DIV = (g == 0) ? 1 : g;
        localparam logic [32:0] RECIP =
            33'(((64'd1 << RECIP_BITS) + (DIV / 2)) / DIV);
        assign recip_rom[g] = RECIP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_family     <= FAM_CHEB;
            r_term_count <= CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FAMILY:     r_family     <= t_family'(i_cfg_data[1:0]);
                REG_TERM_COUNT: r_term_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_term_count == '0) begin
            count_m1 = '0;
        end else if (32'(r_term_count) > MAX_TERMS) begin
            count_m1 = NW'(MAX_TERMS - 1);
        end else begin
            count_m1 = NW'(r_term_count - 1'b1);
        end
    end

    obp_ctrl #(
        .MAX_TERMS (MAX_TERMS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_family   (r_family),
        .i_count_m1 (count_m1),
        .i_mul_done (mul_done),
        .o_busy     (busy),
        .o_order    (order),
        .o_ctrl     (ctrl)
    );

    obp_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ctrl.issue),
        .i_a      (opa),
        .i_b      (opb),
        .i_shift  (ctrl.op.sh),
        .o_done   (mul_done),
        .o_result (mul_res),
        .o_sat    (mul_sat)
    );

    assign x_ext   = {{(VAL_W-ABS_W){r_x[ABS_W-1]}}, r_x};
    assign two_x   = x_ext << 1;
    assign ord_ext = VAL_W'(order);

    always_comb begin
        case (ctrl.op.a)
            SRC_X:     opa = x_ext;
            SRC_TWO_X: opa = two_x;
            SRC_V1:    opa = r_v1;
            SRC_V2:    opa = r_v2;
            SRC_T0:    opa = r_t0;
            SRC_T1:    opa = r_t1;
            default:   opa = '0;
        endcase
        case (ctrl.op.b)
            SRC_V1:      opb = r_v1;
            SRC_V2:      opb = r_v2;
            SRC_D1:      opb = r_d1;
            SRC_D2:      opb = r_d2;
            SRC_T1:      opb = r_t1;
            SRC_T2:      opb = r_t2;
            SRC_C:       opb = (ord_ext << 1) - 1'b1;
            SRC_NM1:     opb = ord_ext - 1'b1;
            SRC_N:       opb = ord_ext;
            SRC_TWO_NM1: opb = (ord_ext - 1'b1) << 1;
            SRC_TWO_N:   opb = ord_ext << 1;
            SRC_TWO:     opb = VAL_W'(2);
            SRC_RECIP:   opb = VAL_W'(recip_rom[order]);
            default:     opb = '0;
        endcase
    end

    // saturating add / subtract, clipped by the sign of the first operand
    always_comb begin
        if (ctrl.op.kind == K_SUB) begin
            sum = opa - opb;
            ovf = (opa[VAL_W-1] != opb[VAL_W-1]) && (sum[VAL_W-1] != opa[VAL_W-1]);
        end else begin
            sum = opa + opb;
            ovf = (opa[VAL_W-1] == opb[VAL_W-1]) && (sum[VAL_W-1] != opa[VAL_W-1]);
        end
        alu_res = ovf ? (opa[VAL_W-1] ? NEG_MIN : POS_MAX) : sum;
    end

    always_comb begin
        if (order == '0) begin
            emit_val   = ONE_VAL;
            emit_slope = '0;
        end else if (order == NW'(1)) begin
            emit_val   = (r_family == FAM_HERM) ? two_x : x_ext;
            emit_slope = (r_family == FAM_HERM) ? (ONE_VAL << 1) : ONE_VAL;
        end else begin
            emit_val   = r_t0;
            emit_slope = r_t1;
        end
    end

    assign order_wide = {{ORD_W{1'b0}}, order};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= ctrl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.load) begin
            r_x       <= i_abscissa;
            r_sat_acc <= 1'b0;
        end
        if (mul_done) begin
            r_sat_acc <= r_sat_acc | mul_sat;
            case (ctrl.op.dst)
                D_T0:    r_t0 <= mul_res;
                D_T1:    r_t1 <= mul_res;
                default: r_t2 <= mul_res;
            endcase
        end
        if (ctrl.alu) begin
            r_sat_acc <= r_sat_acc | ovf;
            case (ctrl.op.dst)
                D_T0:    r_t0 <= alu_res;
                D_T1:    r_t1 <= alu_res;
                default: r_t2 <= alu_res;
            endcase
        end
        if (ctrl.emit) begin
            r_v2          <= r_v1;
            r_v1          <= emit_val;
            r_d2          <= r_d1;
            r_d1          <= emit_slope;
            r_sat_acc     <= 1'b0;
            o_order_index <= order_wide[ORD_W-1:0];
            o_basis_value <= emit_val;
            o_basis_slope <= emit_slope;
            o_saturated   <= r_sat_acc;
            o_last_of_run <= ctrl.last;
        end
    end

    assign o_valid = r_valid;

endmodule

### sim/orthogonal_polynomial_basis_test.sv
`timescale 1ns / 1ps
// self-checking bench for orthogonal_polynomial_basis: directed table, then random phases
// depends on obp_pkg and the block's rtl; each result is checked against a local recurrence or typed row
module orthogonal_polynomial_basis_test;
    import obp_pkg::*;

    localparam int FRAC         = 24;
    localparam int TERMS_MAX    = 16;
    localparam int RANDOM_ITEMS = 200;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 100;

    typedef logic signed [VAL_W-1:0] s64;

    localparam s64 ONE     = 64'sh0000000001000000;
    localparam s64 POS_MAX = 64'sh7FFFFFFFFFFFFFFF;
    localparam s64 NEG_MAX = 64'sh8000000000000000;

    typedef struct {
        logic [ORD_W-1:0] order;
        s64               value;
        s64               slope;
        logic             clipped;
        logic             last;
    } basis_term_t;

    // known = 1: the last result of the run is typed in, all orders below it are trivial
    typedef struct packed {
        t_family          fam;
        logic [CNT_W-1:0] terms;
        logic [ABS_W-1:0] x;
        logic             known;
        s64               value;
        s64               slope;
    } basis_row_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    i_cfg_we = 1'b0;
    logic [0:0]              i_cfg_index = 1'b0;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic signed [ABS_W-1:0] i_abscissa = '0;
    logic                    o_valid;
    logic [ORD_W-1:0]        o_order_index;
    logic signed [VAL_W-1:0] o_basis_value;
    logic signed [VAL_W-1:0] o_basis_slope;
    logic                    o_saturated;
    logic                    o_last_of_run;

    orthogonal_polynomial_basis #(
        .MAX_TERMS(TERMS_MAX),
        .FRAC_BITS(FRAC)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_abscissa(i_abscissa),
        .o_valid(o_valid),
        .o_order_index(o_order_index),
        .o_basis_value(o_basis_value),
        .o_basis_slope(o_basis_slope),
        .o_saturated(o_saturated),
        .o_last_of_run(o_last_of_run)
    );

    always #10 i_clk = ~i_clk;

    // local copy of the recurrence state and the registers
    t_family          family_setting = FAM_CHEB;
    logic [CNT_W-1:0] term_setting = 5'd1;
    s64               val_m1 = '0;
    s64               val_m2 = '0;
    s64               slope_m1 = '0;
    s64               slope_m2 = '0;
    s64               held_x = '0;
    bit               clip_seen;

    basis_term_t expected_terms[$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;

    basis_row_t directed_rows[22] = '{
        '{FAM_CHEB, 5'd1,  29'h1000000,  1'b1, ONE, 64'sd0},
        '{FAM_CHEB, 5'd2,  29'h0800000,  1'b1, 64'sh800000, ONE},
        '{FAM_HERM, 5'd2,  29'h1F400000, 1'b1, 64'shFFFFFFFFFE800000, 64'sh2000000},
        '{FAM_LEG,  5'd2,  29'h8000000,  1'b1, 64'sh8000000, ONE},
        '{FAM_MONO, 5'd2,  29'h10000000, 1'b1, 64'shFFFFFFFFF0000000, ONE},
        '{FAM_CHEB, 5'd0,  29'h1FFFFFFF, 1'b1, ONE, 64'sd0},
        '{FAM_CHEB, 5'd16, 29'h04CCCCD,  1'b0, 64'sd0, 64'sd0},
        '{FAM_CHEB, 5'd16, 29'h1000000,  1'b0, 64'sd0, 64'sd0},
        '{FAM_CHEB, 5'd16, 29'h1F000000, 1'b0, 64'sd0, 64'sd0},
        '{FAM_CHEB, 5'd16, 29'h0FFFFFFF, 1'b0, 64'sd0, 64'sd0},
        '{FAM_LEG,  5'd16, 29'h0B33333,  1'b0, 64'sd0, 64'sd0},
        '{FAM_LEG,  5'd16, 29'h1F000000, 1'b0, 64'sd0, 64'sd0},
        '{FAM_LEG,  5'd16, 29'h8000000,  1'b0, 64'sd0, 64'sd0},
        '{FAM_LEG,  5'd16, 29'h10000000, 1'b0, 64'sd0, 64'sd0},
        '{FAM_LEG,  5'd3,  29'h0,        1'b0, 64'sd0, 64'sd0},
        '{FAM_MONO, 5'd16, 29'h8000000,  1'b0, 64'sd0, 64'sd0},
        '{FAM_MONO, 5'd31, 29'h1F800000, 1'b0, 64'sd0, 64'sd0},
        '{FAM_MONO, 5'd3,  29'h0,        1'b0, 64'sd0, 64'sd0},
        '{FAM_HERM, 5'd16, 29'h1800000,  1'b0, 64'sd0, 64'sd0},
        '{FAM_HERM, 5'd17, 29'h8000000,  1'b0, 64'sd0, 64'sd0},
        '{FAM_HERM, 5'd16, 29'h1FFFFFFF, 1'b0, 64'sd0, 64'sd0},
        '{FAM_HERM, 5'd16, 29'h10000000, 1'b0, 64'sd0, 64'sd0}
    };

    function automatic s64 sat_sum(s64 a, s64 b);
        logic signed [VAL_W:0] r;
        r = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (r[VAL_W] != r[VAL_W-1]) begin
            clip_seen = 1'b1;
            return r[VAL_W] ? NEG_MAX : POS_MAX;
        end
        return r[VAL_W-1:0];
    endfunction

    function automatic s64 sat_diff(s64 a, s64 b);
        logic signed [VAL_W:0] r;
        r = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        if (r[VAL_W] != r[VAL_W-1]) begin
            clip_seen = 1'b1;
            return r[VAL_W] ? NEG_MAX : POS_MAX;
        end
        return r[VAL_W-1:0];
    endfunction

    // exact product, shifted down by s with rounding half away from zero, then clipped
    function automatic s64 mul_round(s64 a, s64 b, int s);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        neg = a[63] ^ b[63];
        ua = a[63] ? ~a + 64'd1 : a;
        ub = b[63] ? ~b + 64'd1 : b;
        p = {64'd0, ua} * {64'd0, ub};
        if (s > 0) p = (p + (128'd1 << (s - 1))) >> s;
        if (p > (neg ? 128'h8000000000000000 : 128'h7FFFFFFFFFFFFFFF)) begin
            clip_seen = 1'b1;
            return neg ? NEG_MAX : POS_MAX;
        end
        return neg ? s64'(~p[63:0] + 64'd1) : s64'(p[63:0]);
    endfunction

    function automatic s64 recip_of(int n);
        logic [63:0] d;
        d = n;
        return s64'(((64'd1 << RECIP_BITS) + d / 2) / d);
    endfunction

    function automatic int run_length();
        int len;
        len = term_setting;
        if (len < 1) len = 1;
        if (len > TERMS_MAX) len = TERMS_MAX;
        return len;
    endfunction

    function automatic void predict_run(logic [ABS_W-1:0] xin);
        s64          x;
        s64          two_x;
        s64          v;
        s64          d;
        s64          v1;
        s64          v2;
        s64          d1;
        s64          d2;
        s64          c;
        int          len;
        int          n;
        basis_term_t t;
        x = {{(VAL_W-ABS_W){xin[ABS_W-1]}}, xin};
        two_x = x * 2;
        held_x = x;
        len = run_length();
        for (n = 0; n < len; n++) begin
            clip_seen = 1'b0;
            v1 = val_m1;
            v2 = val_m2;
            d1 = slope_m1;
            d2 = slope_m2;
            if (n == 0) begin
                v = ONE;
                d = '0;
            end else if (n == 1) begin
                v = (family_setting == FAM_HERM) ? two_x : x;
                d = (family_setting == FAM_HERM) ? 2 * ONE : ONE;
            end else begin
                case (family_setting)
                    FAM_CHEB: begin
                        v = sat_diff(mul_round(two_x, v1, FRAC), v2);
                        d = sat_sum(mul_round(two_x, d1, FRAC), mul_round(v1, 2, 0));
                        d = sat_diff(d, d2);
                    end
                    FAM_LEG: begin
                        c = 2 * n - 1;
                        v = sat_diff(mul_round(x * c, v1, FRAC), mul_round(v2, n - 1, 0));
                        v = mul_round(v, recip_of(n), RECIP_BITS);
                        d = sat_sum(mul_round(v1, c, 0), d2);
                    end
                    FAM_MONO: begin
                        v = mul_round(x, v1, FRAC);
                        d = mul_round(v1, n, 0);
                    end
                    default: begin
                        v = sat_diff(mul_round(two_x, v1, FRAC), mul_round(v2, 2 * (n - 1), 0));
                        d = mul_round(v1, 2 * n, 0);
                    end
                endcase
            end
            val_m2 = v1;
            val_m1 = v;
            slope_m2 = d1;
            slope_m1 = d;
            t.order = ORD_W'(n);
            t.value = v;
            t.slope = d;
            t.clipped = clip_seen;
            t.last = (n + 1 == len);
            expected_terms.push_back(t);
        end
    endfunction

    // rows with a typed answer run at most two orders; order 0 is always one with zero slope
    function automatic void push_known(s64 value, s64 slope);
        basis_term_t t;
        int          len;
        len = run_length();
        if (len == 2) begin
            t = '{order: '0, value: ONE, slope: '0, clipped: 1'b0, last: 1'b0};
            expected_terms.push_back(t);
        end
        t = '{order: ORD_W'(len - 1), value: value, slope: slope, clipped: 1'b0, last: 1'b1};
        expected_terms.push_back(t);
    endfunction

    task automatic report_mismatch(string field, int order, logic [63:0] want, logic [63:0] got);
        $display("mismatch at order %0d, %s: expected %h, got %h", order, field, want, got);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_terms
        basis_term_t want;
        if (i_rst_n && o_valid) begin
            if (expected_terms.size() == 0) begin
                report_mismatch("unexpected result", o_order_index, 64'd0, o_basis_value);
            end else begin
                want = expected_terms.pop_front();
                if (o_order_index !== want.order)
                    report_mismatch("order_index", want.order, want.order, o_order_index);
                if (o_basis_value !== want.value)
                    report_mismatch("basis_value", want.order, want.value, o_basis_value);
                if (o_basis_slope !== want.slope)
                    report_mismatch("basis_slope", want.order, want.slope, o_basis_slope);
                if (o_saturated !== want.clipped)
                    report_mismatch("saturated", want.order, want.clipped, o_saturated);
                if (o_last_of_run !== want.last)
                    report_mismatch("last_of_run", want.order, want.last, o_last_of_run);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // hold start until taken, then idle for a random gap unless in a burst
    task automatic send_item(logic [ABS_W-1:0] x, logic known, s64 value, s64 slope, bit burst);
        int gap;
        start <= 1'b1;
        i_abscissa <= x;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (known) push_known(value, slope);
        else predict_run(x);
        gap = burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_runs();
        start <= 1'b0;
        while (expected_terms.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(t_family fam, logic [CNT_W-1:0] terms);
        drain_runs();
        write_reg(REG_FAMILY, CFG_W'(fam));
        write_reg(REG_TERM_COUNT, terms);
        family_setting = fam;
        term_setting = terms;
    endtask

    // mostly |x| <= 2, some |x| <= 8, some any 29-bit pattern
    function automatic logic [ABS_W-1:0] draw_abscissa();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) return ABS_W'($urandom_range(0, 1 << 26)) - ABS_W'(1 << 25);
        if (pick < 85) return ABS_W'($urandom_range(0, 1 << 28)) - ABS_W'(1 << 27);
        return ABS_W'($urandom());
    endfunction

    function automatic logic [CNT_W-1:0] draw_terms();
        case ($urandom_range(0, 9))
            0: return 5'd0;
            1: return 5'd31;
            2, 3: return 5'd16;
            4: return 5'd17;
            default: return CNT_W'($urandom_range(1, 15));
        endcase
    endfunction

    initial begin : stimulus
        int  sent;
        int  phase_len;
        bit  burst;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // first row runs on the reset settings
        foreach (directed_rows[i]) begin
            if (directed_rows[i].fam != family_setting || directed_rows[i].terms != term_setting)
                configure(directed_rows[i].fam, directed_rows[i].terms);
            send_item(directed_rows[i].x, directed_rows[i].known, directed_rows[i].value,
                      directed_rows[i].slope, 1'b0);
        end
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            configure(t_family'($urandom_range(0, 3)), draw_terms());
            burst = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(8, 24);
            repeat (phase_len) begin
                send_item(draw_abscissa(), 1'b0, '0, '0, burst);
                sent++;
            end
        end
        drain_runs();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
